@@ src/fpa_pkg.sv @@
// package for the fixed point alu: mode and status codes, stage types
package fpa_pkg;

	typedef enum logic [3:0] {
		MODE_ADD = 4'd0, MODE_SUB = 4'd1, MODE_MUL = 4'd2, MODE_DIV = 4'd3,
		MODE_EQ = 4'd4, MODE_NE = 4'd5, MODE_GT = 4'd6, MODE_LT = 4'd7,
		MODE_GE = 4'd8, MODE_LE = 4'd9, MODE_MIN = 4'd10, MODE_MAX = 4'd11,
		MODE_INC = 4'd12, MODE_DEC = 4'd13, MODE_FROM_INT = 4'd14, MODE_TO_INT = 4'd15
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0, ST_OVF = 2'd1, ST_DIV0 = 2'd2
	} status_t;

	// item leaving the simple-op stage towards the output
	typedef struct packed {
		logic [31:0] value;
		logic        cmp;
		status_t     status;
	} res_t;

endpackage

@@ src/fpa_div.sv @@
// pipelined restoring divider, PB quotient bits per stage, ceiling rounding
module fpa_div #(
	parameter int NB = 64,
	parameter int PB = 4
) (
	input  logic          clk,
	input  logic          adv,
	input  logic [NB-1:0] num,
	input  logic [31:0]   den,
	input  logic          neg,
	output logic [NB:0]   quo
);
	localparam int STEPS = NB / PB;

	logic [NB-1:0] q_s [STEPS+1];
	logic [32:0]   r_s [STEPS+1];
	logic [31:0]   d_s [STEPS+1];
	logic          n_s [STEPS+1];

	always_comb begin
		q_s[0] = num;
		r_s[0] = '0;
		d_s[0] = den;
		n_s[0] = neg;
	end

	// each stage resolves PB quotient bits
	for (genvar g = 0; g < STEPS; g++) begin : g_st
		logic [NB-1:0] qn;
		logic [32:0]   rn;
		always_comb begin
			logic [33:0] t;
			qn = q_s[g];
			rn = r_s[g];
			for (int k = 0; k < PB; k++) begin
				t = {rn, qn[NB-1]};
				qn = {qn[NB-2:0], 1'b0};
				if (t >= {2'b0, d_s[g]}) begin
					t = t - {2'b0, d_s[g]};
					qn[0] = 1'b1;
				end
				rn = t[32:0];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				q_s[g+1] <= qn;
				r_s[g+1] <= rn;
				d_s[g+1] <= d_s[g];
				n_s[g+1] <= n_s[g];
			end
		end
	end

	// ceiling: add one for positive quotient with a remainder, negate negative
	always_comb begin
		logic [NB:0] qe;
		qe = {1'b0, q_s[STEPS]};
		if (n_s[STEPS]) quo = ~qe + 1'b1;
		else quo = qe + {{NB{1'b0}}, (r_s[STEPS] != '0)};
	end
endmodule

@@ src/fixed_point_alu_unit.sv @@
// top level of the signed fixed point alu, a deep pipeline with a divider
//
// channel | signals                                      | dir | handshake
// in      | in_valid, in_stall, mode, operand_a,         | in  | valid / stall
//         | operand_b                                    |     |
// out     | out_valid, out_stall, result_value,          | out | valid / stall
//         | compare_true, status                         |     |
//
// one item per cycle while the output is not stalled; the divider stages resolve
// four quotient bits per stage
// reset clears the valid bits only; payload registers take no reset
// a stall at the output freezes the whole pipeline; in_stall follows out_stall
module fixed_point_alu_unit #(
	parameter int FRAC_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [3:0]         mode,
	input  logic signed [31:0] operand_a,
	input  logic signed [31:0] operand_b,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] result_value,
	output logic               compare_true,
	output fpa_pkg::status_t   status
);
	localparam int NB = 64;
	localparam int PB = 4;
	localparam int DL = NB / PB;
	localparam int LAT = DL + 2;

	logic adv;
	assign adv = !(out_valid && out_stall);
	assign in_stall = !adv;

	// stage 1: simple ops, product, divider operands
	fpa_pkg::res_t      r_s1;
	fpa_pkg::mode_t     m_s1;
	logic signed [63:0] p_s1;
	logic [NB-1:0]      num_s1;
	logic [31:0]        den_s1;
	logic               neg_s1, div0_s1, nega_s1;

	always_ff @(posedge clk) begin
		logic signed [33:0] s;
		logic signed [63:0] n;
		logic               c;
		fpa_pkg::res_t      r;
		if (adv) begin
			m_s1 <= fpa_pkg::mode_t'(mode);
			s = '0;
			c = 1'b0;
			unique case (fpa_pkg::mode_t'(mode))
				fpa_pkg::MODE_ADD: s = 34'(operand_a) + 34'(operand_b);
				fpa_pkg::MODE_SUB: s = 34'(operand_a) - 34'(operand_b);
				fpa_pkg::MODE_INC: s = 34'(operand_a) + 34'sd1;
				fpa_pkg::MODE_DEC: s = 34'(operand_a) - 34'sd1;
				fpa_pkg::MODE_EQ: c = operand_a == operand_b;
				fpa_pkg::MODE_NE: c = operand_a != operand_b;
				fpa_pkg::MODE_GT: c = operand_a > operand_b;
				fpa_pkg::MODE_LT: c = operand_a < operand_b;
				fpa_pkg::MODE_GE: c = operand_a >= operand_b;
				fpa_pkg::MODE_LE: c = operand_a <= operand_b;
				fpa_pkg::MODE_MIN: s = 34'((operand_a < operand_b) ? operand_a : operand_b);
				fpa_pkg::MODE_MAX: s = 34'((operand_a > operand_b) ? operand_a : operand_b);
				fpa_pkg::MODE_TO_INT: s = 34'(operand_a >>> FRAC_BITS);
				default: s = '0;
			endcase
			r.cmp = c;
			r.status = fpa_pkg::ST_OK;
			if (s > 34'sh7FFFFFFF) begin
				r.value = 32'h7FFFFFFF;
				r.status = fpa_pkg::ST_OVF;
			end else if (s < -34'sh80000000) begin
				r.value = 32'h80000000;
				r.status = fpa_pkg::ST_OVF;
			end else begin
				r.value = s[31:0];
			end
			r_s1 <= r;
			p_s1 <= 64'(operand_a) * 64'(operand_b);
			n = 64'(operand_a) <<< FRAC_BITS;
			num_s1 <= n[63] ? 64'(-n) : 64'(n);
			den_s1 <= operand_b[31] ? 32'(-operand_b) : operand_b;
			neg_s1 <= n[63] ^ operand_b[31];
			nega_s1 <= n[63];
			div0_s1 <= operand_b == '0;
		end
	end

	// stage 2: ceiling shift of product and from_int, select
	fpa_pkg::res_t  r_s2;
	fpa_pkg::mode_t m_s2;
	logic           div0_s2;
	always_ff @(posedge clk) begin
		logic signed [64:0] w;
		fpa_pkg::res_t      r;
		if (adv) begin
			m_s2 <= m_s1;
			div0_s2 <= div0_s1;
			r = r_s1;
			w = '0;
			if (m_s1 == fpa_pkg::MODE_MUL) begin
				w = (65'(p_s1) + 65'((65'sd1 <<< FRAC_BITS) - 65'sd1)) >>> FRAC_BITS;
			end else begin
				// from_int keeps the sign of the first operand only
				w = 65'(num_s1) <<< 0;
				w = nega_s1 ? 65'(-w) : w;
			end
			if (m_s1 == fpa_pkg::MODE_MUL || m_s1 == fpa_pkg::MODE_FROM_INT) begin
				if (w > 65'sh7FFFFFFF) begin
					r.value = 32'h7FFFFFFF;
					r.status = fpa_pkg::ST_OVF;
				end else if (w < -65'sh80000000) begin
					r.value = 32'h80000000;
					r.status = fpa_pkg::ST_OVF;
				end else begin
					r.value = w[31:0];
				end
			end
			r_s2 <= r;
		end
	end

	// delay line matching the divider
	fpa_pkg::res_t  dr_s [DL];
	fpa_pkg::mode_t dm_s [DL];
	logic           dz_s [DL];
	always_ff @(posedge clk) begin
		if (adv) begin
			dr_s[0] <= r_s2;
			dm_s[0] <= m_s2;
			dz_s[0] <= div0_s2;
			for (int i = 1; i < DL; i++) begin
				dr_s[i] <= dr_s[i-1];
				dm_s[i] <= dm_s[i-1];
				dz_s[i] <= dz_s[i-1];
			end
		end
	end

	// divider starts at stage 1 outputs; one extra register aligns it with stage 2
	logic [NB-1:0] dn_s2;
	logic [31:0]   dd_s2;
	logic          dg_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			dn_s2 <= num_s1;
			dd_s2 <= den_s1;
			dg_s2 <= neg_s1;
		end
	end

	logic [NB:0] quo;
	fpa_div #(.NB(NB), .PB(PB)) u_div (
		.clk(clk), .adv(adv),
		.num(dn_s2), .den(dd_s2), .neg(dg_s2), .quo(quo)
	);

	// valid bits along the pipeline
	logic [LAT-1:0] v_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[LAT-2:0], in_valid};
		end
	end

	// output register
	fpa_pkg::res_t o_q;
	always_ff @(posedge clk) begin
		logic signed [NB:0] qs;
		fpa_pkg::res_t      r;
		if (adv) begin
			r = dr_s[DL-1];
			qs = $signed(quo);
			if (dm_s[DL-1] == fpa_pkg::MODE_DIV) begin
				if (dz_s[DL-1]) begin
					r.value = '0;
					r.status = fpa_pkg::ST_DIV0;
				end else if (qs > 65'sh7FFFFFFF) begin
					r.value = 32'h7FFFFFFF;
					r.status = fpa_pkg::ST_OVF;
				end else if (qs < -65'sh80000000) begin
					r.value = 32'h80000000;
					r.status = fpa_pkg::ST_OVF;
				end else begin
					r.value = qs[31:0];
					r.status = fpa_pkg::ST_OK;
				end
			end
			o_q <= r;
		end
	end

	logic ov_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (adv) ov_q <= v_q[LAT-1];
	end

	assign out_valid = ov_q;
	assign result_value = o_q.value;
	assign compare_true = o_q.cmp;
	assign status = o_q.status;

	// a held result keeps its value while the pipeline is frozen
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_value))
		else $error("held result changed");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall == (out_valid && out_stall))
		else $error("input stall does not follow output");
	a_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && compare_true |-> result_value == '0 && status == fpa_pkg::ST_OK)
		else $error("comparison with value");
endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the fixed point alu: directed table, random items, idling phases
module testbench;

	localparam int FRAC = 8;
	localparam longint MAXV = 64'sd2147483647;
	localparam longint MINV = -64'sd2147483648;
	localparam int LIMIT = 400000;

	typedef struct {
		logic [31:0]      value;
		logic             cmp;
		fpa_pkg::status_t st;
	} alu_res_t;

	typedef struct {
		fpa_pkg::mode_t   md;
		logic [31:0]      a;
		logic [31:0]      b;
		bit               typed;
		logic [31:0]      value;
		logic             cmp;
		fpa_pkg::status_t st;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [3:0] mode = '0;
	logic signed [31:0] operand_a = '0;
	logic signed [31:0] operand_b = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] result_value;
	logic compare_true;
	fpa_pkg::status_t status;

	alu_res_t expected_results[$];
	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_off = 1'b0;
	bit stim_done = 1'b0;

	fixed_point_alu_unit #(.FRAC_BITS(FRAC)) dut (.*);

	// clock
	always #4 clk = ~clk;

	// saturate a wide value to 32 bits
	function automatic longint clamp(input longint v, inout fpa_pkg::status_t st);
		if (v > MAXV) begin
			st = fpa_pkg::ST_OVF;
			return MAXV;
		end
		if (v < MINV) begin
			st = fpa_pkg::ST_OVF;
			return MINV;
		end
		return v;
	endfunction

	// ceiling division, d non-zero
	function automatic longint ceil_div(input longint n, input longint d);
		longint q;
		q = n / d;
		if ((n % d) != 0 && ((n > 0) == (d > 0))) q = q + 1;
		return q;
	endfunction

	// exact result of one alu operation
	function automatic alu_res_t alu_compute(input fpa_pkg::mode_t md, input logic [31:0] ra,
			input logic [31:0] rb);
		alu_res_t res;
		longint a, b, r;
		fpa_pkg::status_t st;
		logic c;
		a = longint'($signed(ra));
		b = longint'($signed(rb));
		r = 0;
		c = 1'b0;
		st = fpa_pkg::ST_OK;
		case (md)
			fpa_pkg::MODE_ADD: r = clamp(a + b, st);
			fpa_pkg::MODE_SUB: r = clamp(a - b, st);
			fpa_pkg::MODE_MUL: r = clamp(ceil_div(a * b, 64'sd1 << FRAC), st);
			fpa_pkg::MODE_DIV: begin
				if (b == 0) st = fpa_pkg::ST_DIV0;
				else r = clamp(ceil_div(a * (64'sd1 << FRAC), b), st);
			end
			fpa_pkg::MODE_EQ: c = (a == b);
			fpa_pkg::MODE_NE: c = (a != b);
			fpa_pkg::MODE_GT: c = (a > b);
			fpa_pkg::MODE_LT: c = (a < b);
			fpa_pkg::MODE_GE: c = (a >= b);
			fpa_pkg::MODE_LE: c = (a <= b);
			fpa_pkg::MODE_MIN: r = (a < b) ? a : b;
			fpa_pkg::MODE_MAX: r = (a > b) ? a : b;
			fpa_pkg::MODE_INC: r = clamp(a + 1, st);
			fpa_pkg::MODE_DEC: r = clamp(a - 1, st);
			fpa_pkg::MODE_FROM_INT: r = clamp(a * (64'sd1 << FRAC), st);
			default: r = a >>> FRAC;
		endcase
		res.value = r[31:0];
		res.cmp = c;
		res.st = st;
		return res;
	endfunction

	// random operand biased towards edge values
	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 9))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'($signed($urandom_range(0, 8)) - 4);
			3: return 32'($urandom_range(0, 4095)) << 8;
			4: return $urandom_range(0, 1) ? 32'($urandom_range(0, 65535))
				: -32'($urandom_range(0, 65535));
			default: return $urandom;
		endcase
	endfunction

	// cycle counter and timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// result checking at the rising edge
	always @(posedge clk) begin
		alu_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$error("result with no expectation: value %h", result_value);
				errors++;
			end else begin
				e = expected_results.pop_front();
				if (result_value !== e.value) begin
					$error("result_value expected %h actual %h", e.value, result_value);
					errors++;
				end
				if (compare_true !== e.cmp) begin
					$error("compare_true expected %b actual %b", e.cmp, compare_true);
					errors++;
				end
				if (status !== e.st) begin
					$error("status expected %0d actual %0d", e.st, status);
					errors++;
				end
			end
		end
	end

	// receiver stalling, driven at the falling edge
	always @(negedge clk) begin
		if (hold_off) out_stall <= 1'b1;
		else out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// long hold-off of the receiver, counted here
	initial begin
		wait (stim_done == 1'b0 && cycles > 300);
		hold_off = 1'b1;
		repeat (120) @(posedge clk);
		hold_off = 1'b0;
	end

	// offer one item and wait for its acceptance
	task automatic send_item(input fpa_pkg::mode_t md, input logic [31:0] a,
			input logic [31:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mode <= md;
		operand_a <= a;
		operand_b <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_results.push_back(alu_compute(md, a, b));
		@(negedge clk);
	endtask

	row_t rows[$];
	alu_res_t typed_res;

	initial begin
		int phase;
		// directed rows; typed results where obvious
		rows = '{
			'{fpa_pkg::MODE_ADD, 32'h7fffffff, 32'h1, 1, 32'h7fffffff, 0, fpa_pkg::ST_OVF},
			'{fpa_pkg::MODE_ADD, 32'h80000000, 32'hffffffff, 1, 32'h80000000, 0,
				fpa_pkg::ST_OVF},
			'{fpa_pkg::MODE_SUB, 32'h80000000, 32'h1, 1, 32'h80000000, 0, fpa_pkg::ST_OVF},
			'{fpa_pkg::MODE_SUB, 32'h7fffffff, 32'hffffffff, 1, 32'h7fffffff, 0,
				fpa_pkg::ST_OVF},
			'{fpa_pkg::MODE_MUL, 32'h7fffffff, 32'h7fffffff, 1, 32'h7fffffff, 0,
				fpa_pkg::ST_OVF},
			'{fpa_pkg::MODE_MUL, 32'h80000000, 32'h7fffffff, 1, 32'h80000000, 0,
				fpa_pkg::ST_OVF},
			'{fpa_pkg::MODE_MUL, 32'h00000180, 32'hffffff80, 0, 0, 0, fpa_pkg::ST_OK},
			'{fpa_pkg::MODE_MUL, 32'h00000001, 32'h00000001, 1, 32'h1, 0, fpa_pkg::ST_OK},
			'{fpa_pkg::MODE_DIV, 32'h00001234, 32'h0, 1, 32'h0, 0, fpa_pkg::ST_DIV0},
			'{fpa_pkg::MODE_DIV, 32'h80000000, 32'h0, 1, 32'h0, 0, fpa_pkg::ST_DIV0},
			'{fpa_pkg::MODE_DIV, 32'h80000000, 32'h1, 1, 32'h80000000, 0, fpa_pkg::ST_OVF},
			'{fpa_pkg::MODE_DIV, 32'h00000100, 32'h00000300, 0, 0, 0, fpa_pkg::ST_OK},
			'{fpa_pkg::MODE_EQ, 32'h5, 32'h5, 1, 32'h0, 1, fpa_pkg::ST_OK},
			'{fpa_pkg::MODE_NE, 32'h5, 32'h5, 1, 32'h0, 0, fpa_pkg::ST_OK},
			'{fpa_pkg::MODE_GT, 32'h7fffffff, 32'h80000000, 1, 32'h0, 1, fpa_pkg::ST_OK},
			'{fpa_pkg::MODE_LT, 32'h7fffffff, 32'h80000000, 1, 32'h0, 0, fpa_pkg::ST_OK},
			'{fpa_pkg::MODE_GE, 32'h80000000, 32'h80000000, 1, 32'h0, 1, fpa_pkg::ST_OK},
			'{fpa_pkg::MODE_LE, 32'h1, 32'hffffffff, 1, 32'h0, 0, fpa_pkg::ST_OK},
			'{fpa_pkg::MODE_MIN, 32'h7fffffff, 32'h80000000, 1, 32'h80000000, 0,
				fpa_pkg::ST_OK},
			'{fpa_pkg::MODE_MAX, 32'h7fffffff, 32'h80000000, 1, 32'h7fffffff, 0,
				fpa_pkg::ST_OK},
			'{fpa_pkg::MODE_INC, 32'h7fffffff, 32'hffffffff, 1, 32'h7fffffff, 0,
				fpa_pkg::ST_OVF},
			'{fpa_pkg::MODE_DEC, 32'h80000000, 32'hffffffff, 1, 32'h80000000, 0,
				fpa_pkg::ST_OVF},
			'{fpa_pkg::MODE_FROM_INT, 32'h00800000, 32'h0, 1, 32'h7fffffff, 0,
				fpa_pkg::ST_OVF},
			'{fpa_pkg::MODE_FROM_INT, 32'hff7fffff, 32'h0, 1, 32'h80000000, 0,
				fpa_pkg::ST_OVF},
			'{fpa_pkg::MODE_TO_INT, 32'hffffff01, 32'h0, 1, 32'hffffffff, 0, fpa_pkg::ST_OK}
		};
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// walk the directed table, cross-check typed rows against the predictor
		foreach (rows[i]) begin
			if (rows[i].typed) begin
				typed_res = alu_compute(rows[i].md, rows[i].a, rows[i].b);
				if (typed_res.value !== rows[i].value || typed_res.cmp !== rows[i].cmp
						|| typed_res.st !== rows[i].st) begin
					$error("table row %0d disagrees with predictor", i);
					errors++;
				end
			end
			send_item(rows[i].md, rows[i].a, rows[i].b);
		end
		// random items over the idling phases
		for (phase = 0; phase < 4; phase++) begin
			send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 77 : 25) : 0;
			recv_stall_pct = (phase == 2) ? 77 : ((phase == 3) ? 25 : 0);
			repeat (445) send_item(fpa_pkg::mode_t'($urandom_range(0, 15)), rand_operand(),
				rand_operand());
			// sender pauses until every result is in
			in_valid <= 1'b0;
			while (expected_results.size() != 0) @(negedge clk);
		end
		stim_done = 1'b1;
		recv_stall_pct = 0;
		repeat (40) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
